>>> design/slow_start_delay_exit_detector_macros.svh
// Assertion macros shared by the checker of the slow start delay exit detector.
`ifndef SLOW_START_DELAY_EXIT_DETECTOR_MACROS_SVH
`define SLOW_START_DELAY_EXIT_DETECTOR_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SDX_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SDX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/sdx_pkg.sv
// Package with the types and constants of the slow start delay exit detector.
`timescale 1ns / 1ps

package sdx_pkg;

  localparam int RTT_W = 16;
  localparam int NUM_W = 62;
  localparam int CNT_W = 8;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int ETA_SHIFT = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [CNT_W-1:0] GOAL_RESET = 8'd8;
  localparam logic [RTT_W-1:0] ETA_FLOOR_RESET = 16'd4;
  localparam logic [RTT_W-1:0] ETA_CEILING_RESET = 16'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_GOAL = 2'd0,
    CFG_ETA_FLOOR = 2'd1,
    CFG_ETA_CEILING = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [RTT_W-1:0] prev_min;
    logic             last_valid;
    logic [RTT_W-1:0] round_min;
    logic [CNT_W-1:0] samples;
  } round_stat_t;

endpackage

>>> design/slow_start_delay_exit_detector.sv
// An accepted transaction passes the input register, then the result register.
// Throughput: one transaction per cycle unless stalled, via the input and result registers.
// With the output stalled, an input transaction is taken only into an empty input register.
// Reset: synchronous, active low; clears round state and restores the register defaults.
`timescale 1ns / 1ps

module slow_start_delay_exit_detector (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sdx_pkg::RTT_W-1:0]     in_rtt_sample,
  input  logic [sdx_pkg::NUM_W-1:0]     in_acked_number,
  input  logic [sdx_pkg::NUM_W-1:0]     in_next_number,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_exit_due,
  input  logic                          cfg_we,
  input  logic [sdx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sdx_pkg::CFG_W-1:0]     cfg_data
);

  logic [sdx_pkg::CNT_W-1:0] sample_goal_r;
  logic [sdx_pkg::RTT_W-1:0] eta_floor_r;
  logic [sdx_pkg::RTT_W-1:0] eta_ceiling_r;

  logic                      s1_valid_r;
  logic [sdx_pkg::RTT_W-1:0] s1_rtt_r;
  logic [sdx_pkg::NUM_W-1:0] s1_acked_r;
  logic [sdx_pkg::NUM_W-1:0] s1_next_r;

  logic                      out_valid_r;
  logic                      out_exit_due_r;

  logic                      advance;
  logic                      s1_move;
  logic                      in_take;
  logic                      exit_due_nxt;
  sdx_pkg::round_stat_t      stat;

  assign advance = !out_valid_r || !out_stall;
  assign s1_move = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;
  assign in_take = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_goal_r <= sdx_pkg::GOAL_RESET;
      eta_floor_r <= sdx_pkg::ETA_FLOOR_RESET;
      eta_ceiling_r <= sdx_pkg::ETA_CEILING_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sdx_pkg::CFG_SAMPLE_GOAL: sample_goal_r <= cfg_data[sdx_pkg::CNT_W-1:0];
        sdx_pkg::CFG_ETA_FLOOR:   eta_floor_r <= cfg_data[sdx_pkg::RTT_W-1:0];
        sdx_pkg::CFG_ETA_CEILING: eta_ceiling_r <= cfg_data[sdx_pkg::RTT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_rtt_r <= in_rtt_sample;
      s1_acked_r <= in_acked_number;
      s1_next_r <= in_next_number;
    end
  end

  sdx_round u_sdx_round (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (s1_move),
    .rtt      (s1_rtt_r),
    .acked    (s1_acked_r),
    .next_num (s1_next_r),
    .stat     (stat)
  );

  sdx_verdict u_sdx_verdict (
    .stat        (stat),
    .sample_goal (sample_goal_r),
    .eta_floor   (eta_floor_r),
    .eta_ceiling (eta_ceiling_r),
    .exit_due    (exit_due_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_exit_due_r <= exit_due_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_exit_due = out_exit_due_r;

endmodule

>>> design/sdx_round.sv
// Round tracking: boundary, round minimum, last round minimum and sample count.
`timescale 1ns / 1ps

module sdx_round (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       upd,
  input  logic [sdx_pkg::RTT_W-1:0]  rtt,
  input  logic [sdx_pkg::NUM_W-1:0]  acked,
  input  logic [sdx_pkg::NUM_W-1:0]  next_num,
  output sdx_pkg::round_stat_t       stat
);

  logic [sdx_pkg::RTT_W-1:0] prev_min_r, prev_min_nxt;
  logic                      last_valid_r, last_valid_nxt;
  logic [sdx_pkg::RTT_W-1:0] round_min_r, round_min_nxt;
  logic                      round_valid_r, round_valid_nxt;
  logic [sdx_pkg::CNT_W-1:0] samples_r, samples_nxt;
  logic [sdx_pkg::NUM_W-1:0] boundary_r, boundary_nxt;
  logic                      armed_r;

  logic                      roll;
  logic [sdx_pkg::RTT_W-1:0] min_base;
  logic                      valid_base;
  logic [sdx_pkg::CNT_W-1:0] cnt_base;

  always_comb begin
    roll = armed_r && (acked >= boundary_r);
    prev_min_nxt = prev_min_r;
    last_valid_nxt = last_valid_r;
    min_base = round_min_r;
    valid_base = round_valid_r;
    cnt_base = samples_r;
    boundary_nxt = boundary_r;
    if (!armed_r) begin
      boundary_nxt = next_num;
    end else if (roll) begin
      prev_min_nxt = round_min_r;
      last_valid_nxt = round_valid_r;
      min_base = '0;
      valid_base = 1'b0;
      cnt_base = '0;
      boundary_nxt = next_num;
    end
    if (!valid_base || (rtt < min_base)) begin
      round_min_nxt = rtt;
    end else begin
      round_min_nxt = min_base;
    end
    round_valid_nxt = 1'b1;
    if (cnt_base != sdx_pkg::CNT_MAX) begin
      samples_nxt = cnt_base + 1'b1;
    end else begin
      samples_nxt = cnt_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_min_r <= '0;
      last_valid_r <= 1'b0;
      round_min_r <= '0;
      round_valid_r <= 1'b0;
      samples_r <= '0;
      boundary_r <= '0;
      armed_r <= 1'b0;
    end else if (upd) begin
      prev_min_r <= prev_min_nxt;
      last_valid_r <= last_valid_nxt;
      round_min_r <= round_min_nxt;
      round_valid_r <= round_valid_nxt;
      samples_r <= samples_nxt;
      boundary_r <= boundary_nxt;
      armed_r <= 1'b1;
    end
  end

  assign stat.prev_min = prev_min_nxt;
  assign stat.last_valid = last_valid_nxt;
  assign stat.round_min = round_min_nxt;
  assign stat.samples = samples_nxt;

endmodule

>>> design/sdx_verdict.sv
// Delay increase verdict: clamped eta, threshold and the exit decision.
`timescale 1ns / 1ps

module sdx_verdict (
  input  sdx_pkg::round_stat_t       stat,
  input  logic [sdx_pkg::CNT_W-1:0]  sample_goal,
  input  logic [sdx_pkg::RTT_W-1:0]  eta_floor,
  input  logic [sdx_pkg::RTT_W-1:0]  eta_ceiling,
  output logic                       exit_due
);

  logic [sdx_pkg::RTT_W-1:0] eta_raw;
  logic [sdx_pkg::RTT_W-1:0] eta;
  logic [sdx_pkg::RTT_W:0]   threshold;

  always_comb begin
    eta_raw = stat.prev_min >> sdx_pkg::ETA_SHIFT;
    if (eta_raw < eta_floor) begin
      eta = eta_floor;
    end else if (eta_raw > eta_ceiling) begin
      eta = eta_ceiling;
    end else begin
      eta = eta_raw;
    end
    threshold = {1'b0, stat.prev_min} + {1'b0, eta};
    exit_due = (stat.samples >= sample_goal) && stat.last_valid &&
               ({1'b0, stat.round_min} >= threshold);
  end

endmodule

>>> design/sdx_checker.sv
// Port-level checker for the slow start delay exit detector and its bind statement.
`timescale 1ns / 1ps
`include "slow_start_delay_exit_detector_macros.svh"

module sdx_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_exit_due
);

  logic in_take;

  assign in_take = in_valid && !in_stall;

  `SDX_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_exit_due), "stalled result transaction changed")
  `SDX_ASSERT_SAME(a_in_free, clk, rst_n, !out_valid, !in_stall, "input stalled while the result register is empty")
  `SDX_ASSERT_SAME(a_out_origin, clk, rst_n, $rose(out_valid), $past(in_take, 2), "result transaction without an input transaction two cycles earlier")

endmodule

bind slow_start_delay_exit_detector sdx_checker u_sdx_checker (.*);

>>> dv/tb.sv
// Self-checking testbench of the slow start delay exit detector: directed table plus random rounds.
`timescale 1ns / 1ps

module tb;

  localparam int RTT_W = sdx_pkg::RTT_W;
  localparam int NUM_W = sdx_pkg::NUM_W;
  localparam int CNT_W = sdx_pkg::CNT_W;
  localparam int CFG_W = sdx_pkg::CFG_W;
  localparam int CFG_IDX_W = sdx_pkg::CFG_IDX_W;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
  localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};
  localparam int NUM_PHASES = 6;

  typedef struct {
    logic [RTT_W-1:0] rtt;
    logic [NUM_W-1:0] acked;
    logic [NUM_W-1:0] nxt;
    bit               pinned;
    bit               exit_due;
  } sample_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [RTT_W-1:0]     in_rtt_sample = '0;
  logic [NUM_W-1:0]     in_acked_number = '0;
  logic [NUM_W-1:0]     in_next_number = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_exit_due;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Own copy of the detector state and thresholds.
  logic [CNT_W-1:0] goal_cfg = sdx_pkg::GOAL_RESET;
  logic [RTT_W-1:0] floor_cfg = sdx_pkg::ETA_FLOOR_RESET;
  logic [RTT_W-1:0] ceil_cfg = sdx_pkg::ETA_CEILING_RESET;
  logic [RTT_W-1:0] prev_min_rtt = '0;
  bit               prev_min_ok = 1'b0;
  logic [RTT_W-1:0] cur_min_rtt = '0;
  bit               cur_min_ok = 1'b0;
  logic [CNT_W-1:0] cur_samples = '0;
  logic [NUM_W-1:0] boundary_pn = '0;
  bit               boundary_set = 1'b0;

  bit   exit_expect_q[$];
  bit   exit_head;
  bit   calm = 1'b0;
  int   errors = 0;
  int   samples_sent = 0;
  int   exits_seen = 0;

  sample_row_t dir_tbl [26] = '{
    '{16'd100,   62'd0,                   62'd10,                  1'b1, 1'b0},
    '{16'd120,   62'd1,                   62'd11,                  1'b0, 1'b0},
    '{16'd120,   62'd2,                   62'd11,                  1'b0, 1'b0},
    '{16'd120,   62'd3,                   62'd11,                  1'b0, 1'b0},
    '{16'd120,   62'd4,                   62'd11,                  1'b0, 1'b0},
    '{16'd120,   62'd6,                   62'd11,                  1'b0, 1'b0},
    '{16'd120,   62'd9,                   62'd11,                  1'b0, 1'b0},
    '{16'd0,     62'd5,                   62'd12,                  1'b0, 1'b0},
    '{16'd200,   62'd10,                  62'd30,                  1'b0, 1'b0},
    '{16'd210,   62'd11,                  62'd31,                  1'b0, 1'b0},
    '{16'd210,   62'd12,                  62'd31,                  1'b0, 1'b0},
    '{16'd205,   62'd20,                  62'd31,                  1'b0, 1'b0},
    '{16'd230,   62'd25,                  62'd32,                  1'b0, 1'b0},
    '{16'd210,   62'd28,                  62'd33,                  1'b0, 1'b0},
    '{16'd210,   62'd29,                  62'd33,                  1'b0, 1'b0},
    '{16'd210,   62'd29,                  62'd34,                  1'b0, 1'b0},
    '{16'hFFFF,  62'd30,                  62'h3FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0},
    '{16'hFFFF,  62'h3FFF_FFFF_FFFF_FFFE, 62'h3FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0},
    '{16'hFFFF,  62'h3FFF_FFFF_FFFF_FFFF, 62'h3FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0},
    '{16'hFFFF,  62'd0,                   62'd0,                   1'b0, 1'b0},
    '{16'hFFFF,  62'd0,                   62'd0,                   1'b0, 1'b0},
    '{16'hFFFF,  62'd0,                   62'd0,                   1'b0, 1'b0},
    '{16'hFFFF,  62'd0,                   62'd0,                   1'b0, 1'b0},
    '{16'hFFFF,  62'd0,                   62'd0,                   1'b0, 1'b0},
    '{16'hFFFF,  62'd0,                   62'd0,                   1'b0, 1'b0},
    '{16'hFFFF,  62'd0,                   62'd0,                   1'b1, 1'b0}
  };

  slow_start_delay_exit_detector i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rtt_sample   (in_rtt_sample),
    .in_acked_number (in_acked_number),
    .in_next_number  (in_next_number),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_exit_due    (out_exit_due),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic bit predict_exit(input logic [RTT_W-1:0] rtt,
                                      input logic [NUM_W-1:0] acked,
                                      input logic [NUM_W-1:0] nxt);
    logic [RTT_W-1:0] eta;
    logic [RTT_W:0]   limit;
    if (!boundary_set) begin
      boundary_pn = nxt;
      boundary_set = 1'b1;
    end else if (acked >= boundary_pn) begin
      prev_min_rtt = cur_min_rtt;
      prev_min_ok = cur_min_ok;
      cur_min_rtt = '0;
      cur_min_ok = 1'b0;
      cur_samples = '0;
      boundary_pn = nxt;
    end
    if (!cur_min_ok || rtt < cur_min_rtt) begin
      cur_min_rtt = rtt;
      cur_min_ok = 1'b1;
    end
    if (cur_samples != sdx_pkg::CNT_MAX)
      cur_samples = cur_samples + 1'b1;
    eta = prev_min_rtt >> sdx_pkg::ETA_SHIFT;
    if (eta < floor_cfg)
      eta = floor_cfg;
    else if (eta > ceil_cfg)
      eta = ceil_cfg;
    limit = {1'b0, prev_min_rtt} + {1'b0, eta};
    return (cur_samples >= goal_cfg) && prev_min_ok && ({1'b0, cur_min_rtt} >= limit);
  endfunction

  task automatic send_sample(input logic [RTT_W-1:0] rtt, input logic [NUM_W-1:0] acked,
                             input logic [NUM_W-1:0] nxt, input bit pinned,
                             input bit pinned_exit);
    int  gap;
    bit  verdict;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rtt_sample <= rtt;
    in_acked_number <= acked;
    in_next_number <= nxt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    verdict = predict_exit(rtt, acked, nxt);
    exit_expect_q.push_back(pinned ? pinned_exit : verdict);
    samples_sent++;
  endtask

  task automatic set_thresholds(input logic [CNT_W-1:0] goal, input logic [RTT_W-1:0] lo,
                                input logic [RTT_W-1:0] hi);
    in_valid <= 1'b0;
    while (exit_expect_q.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= sdx_pkg::CFG_SAMPLE_GOAL;
    cfg_data <= {8'd0, goal};
    @(posedge clk);
    goal_cfg = goal;
    cfg_index <= sdx_pkg::CFG_ETA_FLOOR;
    cfg_data <= lo;
    @(posedge clk);
    floor_cfg = lo;
    cfg_index <= sdx_pkg::CFG_ETA_CEILING;
    cfg_data <= hi;
    @(posedge clk);
    ceil_cfg = hi;
    cfg_index <= CFG_SPARE_IDX;
    cfg_data <= CFG_W'($urandom());
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (exit_expect_q.size() == 0) begin
        $display("%0t: result transaction with nothing expected, expected none, actual %0b",
                 $time, out_exit_due);
        errors++;
      end else begin
        exit_head = exit_expect_q.pop_front();
        if (out_exit_due !== exit_head) begin
          $display("%0t: exit_due mismatch, expected %0b, actual %0b",
                   $time, exit_head, out_exit_due);
          errors++;
        end
        if (out_exit_due === 1'b1)
          exits_seen++;
      end
    end
  end

  initial begin
    int hold;
    forever begin
      hold = calm ? 0 : $urandom_range(0, 5);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    #2_000_000;
    $display("[slow_start_delay_exit_detector] ERROR");
    $finish;
  end

  initial begin
    int               ph;
    int               n;
    int               items;
    int               round_left;
    int               min_len;
    int               max_len;
    int               noise_pct;
    int               d;
    logic [CNT_W-1:0] goal;
    logic [RTT_W-1:0] lo;
    logic [RTT_W-1:0] hi;
    logic [RTT_W-1:0] rtt;
    logic [RTT_W-1:0] base;
    logic [RTT_W:0]   sum;
    logic [NUM_W-1:0] acked;
    logic [NUM_W-1:0] nxt;
    logic [NUM_W-1:0] pn;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tbl[r])
      send_sample(dir_tbl[r].rtt, dir_tbl[r].acked, dir_tbl[r].nxt, dir_tbl[r].pinned,
                  dir_tbl[r].exit_due);

    base = 16'd100;
    pn = '0;
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          goal = 8'd8; lo = 16'd4; hi = 16'd16; items = 300;
          min_len = 4; max_len = 16; noise_pct = 5;
        end
        1: begin
          goal = 8'd0; lo = 16'd20; hi = 16'd5; items = 250;
          min_len = 1; max_len = 10; noise_pct = 5;
        end
        2: begin
          goal = 8'd1; lo = 16'd0; hi = 16'd0; items = 200;
          min_len = 1; max_len = 6; noise_pct = 10;
        end
        3: begin
          goal = 8'd255; lo = 16'd0; hi = 16'hFFFF; items = 600;
          min_len = 250; max_len = 300; noise_pct = 0;
        end
        4: begin
          goal = CNT_W'($urandom_range(1, 30));
          lo = RTT_W'($urandom_range(0, 40));
          hi = RTT_W'($urandom_range(0, 40));
          items = 200; min_len = 2; max_len = 40; noise_pct = 10;
        end
        default: begin
          goal = 8'd2; lo = 16'hFFFF; hi = 16'd0; items = 200;
          min_len = 1; max_len = 8; noise_pct = 15;
        end
      endcase
      set_thresholds(goal, lo, hi);
      round_left = $urandom_range(min_len, max_len);
      for (n = 0; n < items; n++) begin
        if ($urandom_range(0, 99) == 0)
          calm = ~calm;
        if ($urandom_range(0, 99) < noise_pct) begin
          rtt = RTT_W'($urandom());
          acked = NUM_W'({$urandom(), $urandom()});
          nxt = NUM_W'({$urandom(), $urandom()});
        end else begin
          if (round_left == 0) begin
            acked = (boundary_pn > NUM_MAX - 4) ? NUM_MAX : boundary_pn + $urandom_range(0, 3);
            round_left = $urandom_range(min_len, max_len);
            d = $urandom_range(0, 60);
            case ($urandom_range(0, 7))
              0: base = '0;
              1: base = '1;
              2, 3: begin
                sum = {1'b0, base} + d;
                base = sum[RTT_W] ? '1 : sum[RTT_W-1:0];
              end
              4: base = (base > d) ? base - d : '0;
              default: base = (base > 2) ? base - 2 : base + 2;
            endcase
          end else begin
            acked = (boundary_pn > 4) ? boundary_pn - $urandom_range(1, 4) : '0;
          end
          round_left--;
          if (pn < boundary_pn)
            pn = boundary_pn;
          pn = pn + $urandom_range(1, 4);
          nxt = pn;
          sum = {1'b0, base} + $urandom_range(0, 3);
          rtt = sum[RTT_W] ? '1 : sum[RTT_W-1:0];
        end
        send_sample(rtt, acked, nxt, 1'b0, 1'b0);
      end
    end

    in_valid <= 1'b0;
    while (exit_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d RTT samples over %0d threshold settings; %0d exit verdicts seen.",
             samples_sent, NUM_PHASES + 1, exits_seen);
    $display("Mismatches recorded: %0d.", errors);
    if (errors == 0)
      $display("[slow_start_delay_exit_detector] OK");
    else
      $display("[slow_start_delay_exit_detector] ERROR");
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/sdx_pkg.sv
design/sdx_round.sv
design/sdx_verdict.sv
design/slow_start_delay_exit_detector.sv
design/sdx_checker.sv
dv/tb.sv
